@@ rtl/cie_pkg.sv @@
// ============================================================================
// cie_pkg
// Shared widths, constants, types, a quarter-turn function and elaboration-time
// helpers for the circle involute evaluator.
// ============================================================================
package cie_pkg;

  // Field and datapath widths
  localparam int UW    = 32;   // param_u, Q8.24
  localparam int ORD_W = 6;    // order after clamping, covers MAX_ORDER up to 63
  localparam int CW    = 48;   // CORDIC words, Q.40
  localparam int SCW   = 34;   // sine and cosine, Q.30
  localparam int FW    = 44;   // f and g, Q.30
  localparam int WW    = 48;   // rotated vector, Q.30
  localparam int OW    = 48;   // outputs, Q32.16
  localparam int RW    = 32;   // radius, Q16.16
  localparam int DW    = 32;   // direction, Q2.30
  localparam int CFG_W = 48;   // configuration data width
  localparam int IDX_W = 3;    // configuration index width

  localparam logic signed [63:0] HALF_PI_Q52     = 64'sd7074237752028440;
  localparam logic signed [63:0] QUARTER_PI_Q52  = 64'sd3537118876014220;
  localparam logic [31:0]        TWO_OVER_PI_Q32 = 32'd2734261102;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q40 = 48'sd667681663044;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS   = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_DIR_COS  = 3'd3,
    REG_DIR_SIN  = 3'd4
  } cie_reg_e;

  // Side data that travels with each transaction
  typedef struct packed {
    logic signed [UW-1:0] u;
    logic [ORD_W-1:0]     n;
    logic [1:0]           q;
  } cie_tag_t;

  // One result
  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic                 sat;
  } cie_res_t;

  typedef struct packed {
    logic signed [SCW-1:0] s;
    logic signed [SCW-1:0] c;
  } cie_sc_t;

  // Rotate (sin, cos) by m quarter turns
  function automatic cie_sc_t cie_quarter(input logic signed [SCW-1:0] s0,
                                          input logic signed [SCW-1:0] c0,
                                          input logic [1:0] m);
    cie_sc_t r;
    case (m)
      2'd0: begin
        r.s = s0;  r.c = c0;
      end
      2'd1: begin
        r.s = c0;  r.c = -s0;
      end
      2'd2: begin
        r.s = -s0; r.c = -c0;
      end
      default: begin
        r.s = -c0; r.c = s0;
      end
    endcase
    return r;
  endfunction

  // Restoring division, used at elaboration only
  function automatic logic [63:0] cie_udiv(input logic [63:0] num,
                                           input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in Q.40: pi/4 from HALF_PI_Q52 for i = 0, else a series summed in Q.60, then rounded
  function automatic logic signed [CW-1:0] cie_atan_q40(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    logic signed [63:0] rnd;
    int e;
    sum = '0;
    rnd = '0;
    if (i == 0) begin
      rnd = (HALF_PI_Q52 + 64'sd4096) >>> 13;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          term = $signed(cie_udiv(64'd1 << e, 64'(2 * k + 1)));
          sum  = k[0] ? (sum - term) : (sum + term);
        end
      end
      rnd = (sum + 64'sd524288) >>> 20;
    end
    return rnd[CW-1:0];
  endfunction

endpackage

@@ rtl/cie_reduce.sv @@
// ============================================================================
// cie_reduce
// Three-stage range reduction: quadrant estimate by reciprocal multiply,
// remainder, one-step correction and rounding to the CORDIC angle.
// ============================================================================
module cie_reduce import cie_pkg::*; #(
  parameter int MAX_ORDER = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [UW-1:0] u_i,
  input  logic [3:0]           order_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] z_o,
  output cie_tag_t             tag_o
);

  logic                 v1_q, v2_q, v3_q;
  logic signed [UW-1:0] u1_q, u2_q;
  logic [ORD_W-1:0]     n1_q, n2_q;
  logic signed [64:0]   prod_d, prod_q;
  logic [ORD_W-1:0]     n_d;
  logic signed [64:0]   q0_full;
  logic signed [8:0]    q0_d, q0_q;
  logic signed [63:0]   t_d, r0_d, r0_q;
  logic signed [63:0]   r_d;
  logic signed [8:0]    q_d;
  logic signed [63:0]   zr_d;
  logic signed [CW-1:0] z_q;
  cie_tag_t             tag_q;

  // Clamp the order and estimate u * 2/pi
  assign n_d    = (ORD_W'(order_i) > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
                                                        : ORD_W'(order_i);
  assign prod_d = 65'(u_i) * $signed({33'd0, TWO_OVER_PI_Q32});

  // Round the estimate, form the remainder against the shifted parameter
  assign q0_full = (prod_q + (65'sd1 <<< 55)) >>> 56;
  assign q0_d    = q0_full[8:0];
  assign t_d     = (64'(u1_q) <<< 28) + QUARTER_PI_Q52;
  assign r0_d    = t_d - 64'(q0_d) * HALF_PI_Q52;

  // Correct the estimate by one quadrant either way and round to Q.40
  always_comb begin
    if (r0_q < 64'sd0) begin
      q_d = q0_q - 9'sd1;
      r_d = r0_q + HALF_PI_Q52 - QUARTER_PI_Q52;
    end else if (r0_q >= HALF_PI_Q52) begin
      q_d = q0_q + 9'sd1;
      r_d = r0_q - HALF_PI_Q52 - QUARTER_PI_Q52;
    end else begin
      q_d = q0_q;
      r_d = r0_q - QUARTER_PI_Q52;
    end
  end
  assign zr_d = (r_d + 64'sd2048) >>> 12;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q    <= u_i;
      n1_q    <= n_d;
      prod_q  <= prod_d;
      u2_q    <= u1_q;
      n2_q    <= n1_q;
      q0_q    <= q0_d;
      r0_q    <= r0_d;
      z_q     <= zr_d[CW-1:0];
      tag_q.u <= u2_q;
      tag_q.n <= n2_q;
      tag_q.q <= q_d[1:0];
    end
  end

  assign valid_o = v3_q;
  assign z_o     = z_q;
  assign tag_o   = tag_q;

endmodule

@@ rtl/cie_cordic.sv @@
// ============================================================================
// cie_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ============================================================================
module cie_cordic import cie_pkg::*; #(
  parameter int STEPS = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] z_i,
  input  cie_tag_t             tag_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output cie_tag_t             tag_o
);

  logic                 v_q   [STEPS];
  logic signed [CW-1:0] x_q   [STEPS];
  logic signed [CW-1:0] y_q   [STEPS];
  logic signed [CW-1:0] z_q   [STEPS-1];
  cie_tag_t             tag_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [CW-1:0] ATAN = cie_atan_q40(i);
    logic                 v_in;
    logic signed [CW-1:0] x_in, y_in, z_in;
    cie_tag_t             tag_in;
    logic signed [CW-1:0] x_d, y_d, z_d;

    // Take the previous stage, or the seed vector at the first
    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign x_in   = CORDIC_GAIN_Q40;
      assign y_in   = '0;
      assign z_in   = z_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    // Rotate towards zero residual angle
    always_comb begin
      if (z_in >= 0) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - ATAN;
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]   <= x_d;
        y_q[i]   <= y_d;
        tag_q[i] <= tag_in;
      end
    end

    // The residual angle is not needed after the last step
    if (i < STEPS - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= z_d;
        end
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign x_o     = x_q[STEPS-1];
  assign y_o     = y_q[STEPS-1];
  assign tag_o   = tag_q[STEPS-1];

endmodule

@@ rtl/cie_eval.sv @@
// ============================================================================
// cie_eval
// Seven-stage evaluation: quarter-turn shifts, involute terms f and g,
// rotation into the frame, radius scaling, origin and saturation.
// ============================================================================
module cie_eval import cie_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  cie_tag_t             tag_i,
  input  logic [RW-1:0]        radius_i,
  input  logic signed [OW-1:0] origin_x_i,
  input  logic signed [OW-1:0] origin_y_i,
  input  logic signed [DW-1:0] dir_cos_i,
  input  logic signed [DW-1:0] dir_sin_i,
  output logic                 valid_o,
  output cie_res_t             res_o
);

  localparam int PW  = UW + SCW;          // u * sin
  localparam int NW  = ORD_W + 1 + SCW;   // n * sin
  localparam int SW  = PW + 2;            // f, g sums
  localparam int MW  = FW + DW;           // f * dir
  localparam int HW  = FW - 16 + DW;      // upper part of f times dir
  localparam int LW  = 17 + DW;           // lower 16 bits of f times dir
  localparam int XW  = RW + 1 + WW;       // radius * w
  localparam int RHW = RW + 1 + WW - 16;  // radius times upper part of w
  localparam int RLW = RW + 1 + 17;       // radius times lower 16 bits of w
  localparam int TW  = OW + 4;            // scaled result plus origin

  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = -TW'(64'sd1 <<< (OW - 1));

  logic [7:1] v_q;

  // Stage 1: sin and cos to Q.30, quarter shifts
  logic signed [CW-1:0]  s0_w, c0_w;
  logic [1:0]            qb_d;
  cie_sc_t               scn_d, sc1_d, scn1_q, sc11_q;
  cie_tag_t              tag1_q;
  assign s0_w  = (y_i + CW'(512)) >>> 10;
  assign c0_w  = (x_i + CW'(512)) >>> 10;
  assign qb_d  = tag_i.q + tag_i.n[1:0];
  assign scn_d = cie_quarter(s0_w[SCW-1:0], c0_w[SCW-1:0], qb_d);
  assign sc1_d = cie_quarter(s0_w[SCW-1:0], c0_w[SCW-1:0], qb_d + 2'd3);

  // Stage 2: products with u and n
  logic signed [PW-1:0]  pus_q, puc_q;
  logic signed [NW-1:0]  ns1_q, nc1_q;
  cie_sc_t               scn2_q;
  cie_tag_t              tag2_q;

  // Stage 3: f and g
  logic signed [SW-1:0]  f_sum, g_sum;
  logic signed [FW-1:0]  f_q, g_q;
  cie_tag_t              tag3_q;
  assign f_sum = (SW'(scn2_q.c) <<< 24) + SW'(pus_q) + (SW'(ns1_q) <<< 24)
               + (SW'(1) <<< 23);
  assign g_sum = (SW'(scn2_q.s) <<< 24) - SW'(puc_q) - (SW'(nc1_q) <<< 24)
               + (SW'(1) <<< 23);

  // Stage 4: partial products with the direction, split at bit 16 of f and g
  logic signed [HW-1:0]  pfch_q, pgsh_q, pfsh_q, pgch_q;
  logic signed [LW-1:0]  pfcl_q, pgsl_q, pfsl_q, pgcl_q;
  cie_tag_t              tag4_q;

  // Stage 5: combine the partial products, rotated vector
  logic signed [MW-1:0]  pfc_w, pgs_w, pfs_w, pgc_w;
  logic signed [MW:0]    wx_sum, wy_sum;
  logic signed [WW-1:0]  wx_q, wy_q;
  cie_tag_t              tag5_q;
  assign pfc_w  = (MW'(pfch_q) <<< 16) + MW'(pfcl_q);
  assign pgs_w  = (MW'(pgsh_q) <<< 16) + MW'(pgsl_q);
  assign pfs_w  = (MW'(pfsh_q) <<< 16) + MW'(pfsl_q);
  assign pgc_w  = (MW'(pgch_q) <<< 16) + MW'(pgcl_q);
  assign wx_sum = (MW+1)'(pfc_w) - (MW+1)'(pgs_w) + ((MW+1)'(1) <<< 29);
  assign wy_sum = (MW+1)'(pfs_w) + (MW+1)'(pgc_w) + ((MW+1)'(1) <<< 29);

  // Stage 6: partial radius products, split at bit 16 of the vector
  logic signed [RHW-1:0] pxh_q, pyh_q;
  logic signed [RLW-1:0] pxl_q, pyl_q;
  logic                  pnt6_q;

  // Stage 7: combine, round, add origin on the point, saturate
  logic signed [XW-1:0]  px_w, py_w;
  logic signed [XW-1:0]  tx_r, ty_r;
  logic signed [TW-1:0]  tx_d, ty_d;
  logic                  satx, saty;
  cie_res_t              res_d, res_q;
  assign px_w = (XW'(pxh_q) <<< 16) + XW'(pxl_q);
  assign py_w = (XW'(pyh_q) <<< 16) + XW'(pyl_q);
  assign tx_r = (px_w + (XW'(1) <<< 29)) >>> 30;
  assign ty_r = (py_w + (XW'(1) <<< 29)) >>> 30;
  assign tx_d = tx_r[TW-1:0] + (pnt6_q ? TW'(origin_x_i) : TW'(0));
  assign ty_d = ty_r[TW-1:0] + (pnt6_q ? TW'(origin_y_i) : TW'(0));
  assign satx = (tx_d > SAT_HI) || (tx_d < SAT_LO);
  assign saty = (ty_d > SAT_HI) || (ty_d < SAT_LO);

  always_comb begin
    res_d.x   = satx ? ((tx_d > SAT_HI) ? SAT_HI[OW-1:0] : SAT_LO[OW-1:0])
                     : tx_d[OW-1:0];
    res_d.y   = saty ? ((ty_d > SAT_HI) ? SAT_HI[OW-1:0] : SAT_LO[OW-1:0])
                     : ty_d[OW-1:0];
    res_d.sat = satx | saty;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:1], valid_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scn1_q <= scn_d;
      sc11_q <= sc1_d;
      tag1_q <= tag_i;

      pus_q  <= PW'(tag1_q.u) * PW'(scn1_q.s);
      puc_q  <= PW'(tag1_q.u) * PW'(scn1_q.c);
      ns1_q  <= NW'($signed({1'b0, tag1_q.n})) * NW'(sc11_q.s);
      nc1_q  <= NW'($signed({1'b0, tag1_q.n})) * NW'(sc11_q.c);
      scn2_q <= scn1_q;
      tag2_q <= tag1_q;

      f_q    <= f_sum[FW+23:24];
      g_q    <= g_sum[FW+23:24];
      tag3_q <= tag2_q;

      pfch_q <= HW'($signed(f_q[FW-1:16])) * HW'(dir_cos_i);
      pgsh_q <= HW'($signed(g_q[FW-1:16])) * HW'(dir_sin_i);
      pfsh_q <= HW'($signed(f_q[FW-1:16])) * HW'(dir_sin_i);
      pgch_q <= HW'($signed(g_q[FW-1:16])) * HW'(dir_cos_i);
      pfcl_q <= LW'($signed({1'b0, f_q[15:0]})) * LW'(dir_cos_i);
      pgsl_q <= LW'($signed({1'b0, g_q[15:0]})) * LW'(dir_sin_i);
      pfsl_q <= LW'($signed({1'b0, f_q[15:0]})) * LW'(dir_sin_i);
      pgcl_q <= LW'($signed({1'b0, g_q[15:0]})) * LW'(dir_cos_i);
      tag4_q <= tag3_q;

      wx_q   <= wx_sum[WW+29:30];
      wy_q   <= wy_sum[WW+29:30];
      tag5_q <= tag4_q;

      pxh_q  <= RHW'($signed({1'b0, radius_i})) * RHW'($signed(wx_q[WW-1:16]));
      pyh_q  <= RHW'($signed({1'b0, radius_i})) * RHW'($signed(wy_q[WW-1:16]));
      pxl_q  <= RLW'($signed({1'b0, radius_i})) * RLW'($signed({1'b0, wx_q[15:0]}));
      pyl_q  <= RLW'($signed({1'b0, radius_i})) * RLW'($signed({1'b0, wy_q[15:0]}));
      pnt6_q <= (tag5_q.n == '0);

      res_q  <= res_d;
    end
  end

  assign valid_o = v_q[7];
  assign res_o   = res_q;

endmodule

@@ rtl/cie_outbuf.sv @@
// ============================================================================
// cie_outbuf
// Two-entry output buffer: an output register and a skid register, so that
// the pipeline keeps moving while a result waits.
// ============================================================================
module cie_outbuf import cie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cie_res_t res_i,
  output logic     ready_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cie_res_t res_o
);

  logic     out_v_q, skid_v_q;
  cie_res_t out_q, skid_q;
  logic     pop;

  assign pop     = out_v_q & ~out_stall_i;
  assign ready_o = ~skid_v_q;

  // Occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= push_i;
      end else begin
        out_v_q  <= push_i;
      end
    end else if (push_i) begin
      if (out_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q  <= 1'b1;
      end
    end
  end

  // Data movement
  always_ff @(posedge clk_i) begin
    if (pop && skid_v_q) begin
      out_q <= skid_q;
      if (push_i) begin
        skid_q <= res_i;
      end
    end else if (push_i) begin
      if (out_v_q && !pop) begin
        skid_q <= res_i;
      end else begin
        out_q  <= res_i;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without a head entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> !push_i)
    else $error("transaction pushed into a full output buffer");

  a_stalled_head_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> (out_v_q && $stable(out_q)))
    else $error("stalled result lost or changed");

endmodule

@@ rtl/circle_involute_evaluator_core.sv @@
// ============================================================================
// circle_involute_evaluator_core
// Evaluates the involute of a circle, or its n-th derivative, at a
// parameter u in fixed point, with saturation of the 48-bit outputs.
// ============================================================================
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | in        | in_valid_i / in_stall_o   | param_u_i, order_i
//  out     | out       | out_valid_o / out_stall_i | out_x_o, out_y_o,
//          |           |                           | saturated_o
//  cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
//  One transaction per cycle while in_stall_o is low; the CORDIC does one
//  micro-rotation per stage.
//  Reset clears the valid bits and loads the registers with radius 1.0,
//  origin 0 and x-direction (1, 0).
//  A stalled output holds in the output register; one more result lands in
//  the skid register, and only then does in_stall_o rise.
// ============================================================================
module circle_involute_evaluator_core import cie_pkg::*; #(
  parameter int MAX_ORDER    = 15,
  parameter int CORDIC_STEPS = 28
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [UW-1:0]    param_u_i,
  input  logic [3:0]              order_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OW-1:0]    out_x_o,
  output logic signed [OW-1:0]    out_y_o,
  output logic                    saturated_o,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i
);

  logic [RW-1:0]        radius_q;
  logic signed [OW-1:0] origin_x_q, origin_y_q;
  logic signed [DW-1:0] dir_cos_q, dir_sin_q;

  logic                 adv;
  logic                 red_v, cor_v, ev_v;
  logic signed [CW-1:0] red_z, cor_x, cor_y;
  cie_tag_t             red_tag, cor_tag;
  cie_res_t             ev_res, out_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RW'(65536);
      origin_x_q <= '0;
      origin_y_q <= '0;
      dir_cos_q  <= DW'(1073741824);
      dir_sin_q  <= '0;
    end else if (cfg_we_i) begin
      case (cie_reg_e'(cfg_idx_i))
        REG_RADIUS:   radius_q   <= cfg_wdata_i[RW-1:0];
        REG_ORIGIN_X: origin_x_q <= cfg_wdata_i[OW-1:0];
        REG_ORIGIN_Y: origin_y_q <= cfg_wdata_i[OW-1:0];
        REG_DIR_COS:  dir_cos_q  <= cfg_wdata_i[DW-1:0];
        REG_DIR_SIN:  dir_sin_q  <= cfg_wdata_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline while the skid register is free
  assign in_stall_o = ~adv;

  cie_reduce #(.MAX_ORDER(MAX_ORDER)) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .u_i     (param_u_i),
    .order_i (order_i),
    .valid_o (red_v),
    .z_o     (red_z),
    .tag_o   (red_tag)
  );

  cie_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (red_v),
    .z_i     (red_z),
    .tag_i   (red_tag),
    .valid_o (cor_v),
    .x_o     (cor_x),
    .y_o     (cor_y),
    .tag_o   (cor_tag)
  );

  cie_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (cor_v),
    .x_i        (cor_x),
    .y_i        (cor_y),
    .tag_i      (cor_tag),
    .radius_i   (radius_q),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .dir_cos_i  (dir_cos_q),
    .dir_sin_i  (dir_sin_q),
    .valid_o    (ev_v),
    .res_o      (ev_res)
  );

  cie_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv & ev_v),
    .res_i       (ev_res),
    .ready_o     (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign out_x_o     = out_res.x;
  assign out_y_o     = out_res.y;
  assign saturated_o = out_res.sat;

endmodule
